/* hdl/ray_triangle_intersect_macros.svh */
// Assertion macros of the ray/triangle intersection RTL (used by rti_div).
// Each macro expands to one labeled concurrent assertion on clk_i.
`ifndef RAY_TRIANGLE_INTERSECT_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_MACROS_SVH

// Checked only while the block is out of reset.
`define RTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every clock edge, reset included.
`define RTI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

/* hdl/rti_pkg.sv */
// ----------------------------------------------------------------------------
// rti_pkg
// Shared codes and constants of the ray/triangle intersection block.
// ----------------------------------------------------------------------------
package rti_pkg;

  // Width of the configuration index and data fields.
  localparam int unsigned CfgIdxWidth   = 3;
  localparam int unsigned CfgDataWidth  = 32;
  localparam int unsigned DetFloorWidth = 32;
  localparam int unsigned CauseWidth    = 3;

  // Result code: hit, or the first test that failed.
  typedef enum logic [CauseWidth-1:0] {
    CAUSE_HIT      = 3'd0,
    CAUSE_PARALLEL = 3'd1,
    CAUSE_U_OUT    = 3'd2,
    CAUSE_V_OUT    = 3'd3,
    CAUSE_T_OUT    = 3'd4
  } cause_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_START_X   = 3'd0,
    REG_START_Y   = 3'd1,
    REG_START_Z   = 3'd2,
    REG_DIR_X     = 3'd3,
    REG_DIR_Y     = 3'd4,
    REG_DIR_Z     = 3'd5,
    REG_DET_FLOOR = 3'd6
  } cfg_reg_e;

endpackage

/* hdl/rti_geom.sv */
// ----------------------------------------------------------------------------
// rti_geom
// Edge vectors and the two cross products p = dir x e2 and q = s x e1,
// three pipeline stages.
// ----------------------------------------------------------------------------
module rti_geom #(
  parameter int unsigned CW = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [CW-1:0]         va_i [3],
  input  logic signed [CW-1:0]         vb_i [3],
  input  logic signed [CW-1:0]         vc_i [3],
  input  logic signed [CW-1:0]         start_i [3],
  input  logic signed [CW-1:0]         dir_i [3],
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [CW:0]           e1_o [3],
  output logic signed [CW:0]           e2_o [3],
  output logic signed [CW:0]           s_o [3],
  output logic signed [CW:0]           d_o [3],
  output logic signed [2*CW+2:0]       p_o [3],
  output logic signed [2*CW+2:0]       q_o [3]
);
  localparam int unsigned EW = CW + 1;
  localparam int unsigned MW = 2 * EW;
  localparam int unsigned PW = MW + 1;
  localparam int unsigned NS = 3;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  logic signed [EW-1:0] e1_d [3], e2_d [3], s_d [3], d_d [3];
  logic signed [EW-1:0] e1_q [NS][3], e2_q [NS][3], s_q [NS][3], d_q [NS][3];
  logic signed [MW-1:0] pa_d [3], pb_d [3], qa_d [3], qb_d [3];
  logic signed [MW-1:0] pa_q [3], pb_q [3], qa_q [3], qb_q [3];
  logic signed [PW-1:0] p_d [3], q_d [3], p_q [3], q_q [3];

  // A stage loads when it is empty or the next one moves on.
  always_comb begin
    en[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 1: edges and the start point relative to vertex a.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1_d[i] = EW'(vb_i[i]) - EW'(va_i[i]);
      e2_d[i] = EW'(vc_i[i]) - EW'(va_i[i]);
      s_d[i]  = EW'(start_i[i]) - EW'(va_i[i]);
      d_d[i]  = EW'(dir_i[i]);
    end
  end

  // Stage 2: the twelve cross product terms.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pa_d[k] = MW'(d_q[0][(k+1)%3]) * MW'(e2_q[0][(k+2)%3]);
      pb_d[k] = MW'(d_q[0][(k+2)%3]) * MW'(e2_q[0][(k+1)%3]);
      qa_d[k] = MW'(s_q[0][(k+1)%3]) * MW'(e1_q[0][(k+2)%3]);
      qb_d[k] = MW'(s_q[0][(k+2)%3]) * MW'(e1_q[0][(k+1)%3]);
    end
  end

  // Stage 3: differences of the terms give p and q.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p_d[k] = PW'(pa_q[k]) - PW'(pb_q[k]);
      q_d[k] = PW'(qa_q[k]) - PW'(qb_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      e1_q[0] <= e1_d;
      e2_q[0] <= e2_d;
      s_q[0]  <= s_d;
      d_q[0]  <= d_d;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        e1_q[k] <= e1_q[k-1];
        e2_q[k] <= e2_q[k-1];
        s_q[k]  <= s_q[k-1];
        d_q[k]  <= d_q[k-1];
      end
    end
    if (en[1]) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
      qa_q <= qa_d;
      qb_q <= qb_d;
    end
    if (en[2]) begin
      p_q <= p_d;
      q_q <= q_d;
    end
  end

  assign e1_o = e1_q[NS-1];
  assign e2_o = e2_q[NS-1];
  assign s_o  = s_q[NS-1];
  assign d_o  = d_q[NS-1];
  assign p_o  = p_q;
  assign q_o  = q_q;

endmodule

/* hdl/rti_dot.sv */
// ----------------------------------------------------------------------------
// rti_dot
// Dot products for det and the u, v, t numerators, sign folding and the
// bound tests; five pipeline stages.
// ----------------------------------------------------------------------------
module rti_dot #(
  parameter int unsigned CW = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [CW:0]           e1_i [3],
  input  logic signed [CW:0]           e2_i [3],
  input  logic signed [CW:0]           s_i [3],
  input  logic signed [CW:0]           d_i [3],
  input  logic signed [2*CW+2:0]       p_i [3],
  input  logic signed [2*CW+2:0]       q_i [3],
  input  logic [rti_pkg::DetFloorWidth-1:0] det_floor_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output rti_pkg::cause_e              cause_o,
  output logic signed [3*CW+5:0]       det_o,
  output logic signed [3*CW+5:0]       tn_o
);
  import rti_pkg::*;

  localparam int unsigned EW  = CW + 1;
  localparam int unsigned PW  = 2 * CW + 3;
  localparam int unsigned LW  = PW / 2;
  localparam int unsigned HW  = PW - LW;
  localparam int unsigned PPW = EW + PW;
  localparam int unsigned DW  = PPW + 2;
  localparam int unsigned NS  = 5;
  // Dot products: 0 det, 1 u numerator, 2 v numerator, 3 t numerator.
  localparam int unsigned ND  = 4;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  logic signed [EW-1:0]      x_s [ND][3];
  logic signed [PW-1:0]      y_s [ND][3];
  logic signed [EW+LW:0]     lo_d [ND][3], lo_q [ND][3];
  logic signed [EW+HW-1:0]   hi_d [ND][3], hi_q [ND][3];
  logic signed [PPW-1:0]     pr_d [ND][3], pr_q [ND][3];
  logic signed [DW-1:0]      sum_d [ND], sum_q [ND];
  logic signed [DW-1:0]      fold_d [ND], fold_q [ND];
  logic signed [DW:0]        uv_sum;
  logic signed [DW-1:0]      floor_v;
  cause_e                    cause_d, cause_q;
  logic signed [DW-1:0]      det_q, tn_q;

  always_comb begin
    en[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Operand pairs of the four dot products.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      x_s[0][k] = e1_i[k];
      y_s[0][k] = p_i[k];
      x_s[1][k] = s_i[k];
      y_s[1][k] = p_i[k];
      x_s[2][k] = d_i[k];
      y_s[2][k] = q_i[k];
      x_s[3][k] = e2_i[k];
      y_s[3][k] = q_i[k];
    end
  end

  // Stage 1: each product is split into a low and a high partial product.
  always_comb begin
    for (int j = 0; j < ND; j++) begin
      for (int k = 0; k < 3; k++) begin
        lo_d[j][k] = (EW+LW+1)'(x_s[j][k])
                   * (EW+LW+1)'($signed({1'b0, y_s[j][k][LW-1:0]}));
        hi_d[j][k] = (EW+HW)'(x_s[j][k])
                   * (EW+HW)'($signed(y_s[j][k][PW-1:LW]));
      end
    end
  end

  // Stage 2: recombine the partial products.
  always_comb begin
    for (int j = 0; j < ND; j++) begin
      for (int k = 0; k < 3; k++) begin
        pr_d[j][k] = (PPW'(hi_q[j][k]) <<< LW) + PPW'(lo_q[j][k]);
      end
    end
  end

  // Stage 3: sum of the three products.
  always_comb begin
    for (int j = 0; j < ND; j++) begin
      sum_d[j] = DW'(pr_q[j][0]) + DW'(pr_q[j][1]) + DW'(pr_q[j][2]);
    end
  end

  // Stage 4: fold the sign of det into every value.
  always_comb begin
    for (int j = 0; j < ND; j++) begin
      fold_d[j] = sum_q[0][DW-1] ? -sum_q[j] : sum_q[j];
    end
  end

  // Stage 5: bound tests in priority order.
  always_comb begin
    floor_v = (det_floor_i == '0) ? DW'(1) : DW'($signed({1'b0, det_floor_i}));
    uv_sum  = (DW+1)'(fold_q[1]) + (DW+1)'(fold_q[2]);
    if (fold_q[0] < floor_v) begin
      cause_d = CAUSE_PARALLEL;
    end else if (fold_q[1][DW-1] || (fold_q[1] > fold_q[0])) begin
      cause_d = CAUSE_U_OUT;
    end else if (fold_q[2][DW-1] || (uv_sum > (DW+1)'(fold_q[0]))) begin
      cause_d = CAUSE_V_OUT;
    end else if (fold_q[3][DW-1] || (fold_q[3] > fold_q[0])) begin
      cause_d = CAUSE_T_OUT;
    end else begin
      cause_d = CAUSE_HIT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
    if (en[1]) pr_q <= pr_d;
    if (en[2]) sum_q <= sum_d;
    if (en[3]) fold_q <= fold_d;
    if (en[4]) begin
      cause_q <= cause_d;
      det_q   <= fold_q[0];
      tn_q    <= fold_q[3];
    end
  end

  assign cause_o = cause_q;
  assign det_o   = det_q;
  assign tn_o    = tn_q;

endmodule

/* hdl/rti_div.sv */
// ----------------------------------------------------------------------------
// rti_div
// Pipelined restoring divider for t = t_n / det, one quotient bit per
// stage, integer bit first and then the fraction bits.
// ----------------------------------------------------------------------------
`include "ray_triangle_intersect_macros.svh"

module rti_div #(
  parameter int unsigned DW = 78,
  parameter int unsigned F  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rti_pkg::cause_e       cause_i,
  input  logic signed [DW-1:0]  det_i,
  input  logic signed [DW-1:0]  tn_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rti_pkg::cause_e       cause_o,
  output logic [F:0]            quot_o
);
  import rti_pkg::*;

  localparam int unsigned NS = F + 1;
  localparam int unsigned RW = DW + 1;
  localparam logic [F:0]  QMax = (F+1)'(1) << F;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  logic [RW-1:0] r_q [NS], det_q [NS];
  logic [F:0]    q_q [NS];
  cause_e        cause_q [NS];
  logic [RW-1:0] rin [NS], din [NS], r_d [NS];
  logic [F:0]    qin [NS], q_d [NS];
  cause_e        cin [NS];

  always_comb begin
    en[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Partial remainder entering each stage; doubled after the first one.
  always_comb begin
    rin[0] = {1'b0, tn_i};
    din[0] = {1'b0, det_i};
    qin[0] = '0;
    cin[0] = cause_i;
    for (int k = 1; k < NS; k++) begin
      rin[k] = {r_q[k-1][RW-2:0], 1'b0};
      din[k] = det_q[k-1];
      qin[k] = q_q[k-1];
      cin[k] = cause_q[k-1];
    end
  end

  // One compare and subtract per stage.
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      if (rin[k] >= din[k]) begin
        r_d[k] = rin[k] - din[k];
        q_d[k] = {qin[k][F-1:0], 1'b1};
      end else begin
        r_d[k] = rin[k];
        q_d[k] = {qin[k][F-1:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        r_q[k]     <= r_d[k];
        q_q[k]     <= q_d[k];
        det_q[k]   <= din[k];
        cause_q[k] <= cin[k];
      end
    end
  end

  assign cause_o = cause_q[NS-1];
  assign quot_o  = q_q[NS-1];

  // A hit has t in [0,1], so the quotient never passes one.
  `RTI_ASSERT(a_quot_range, (v_q[NS-1] && cause_q[NS-1] == CAUSE_HIT) |-> (q_q[NS-1] <= QMax), "quotient above one on a hit")
  // The remainder of a hit stays below the divisor.
  `RTI_ASSERT(a_rem_below, (v_q[NS-1] && cause_q[NS-1] == CAUSE_HIT) |-> (r_q[NS-1] < det_q[NS-1]), "remainder not below det")
  // A result waiting on a stalled receiver is kept.
  `RTI_ASSERT(a_stall_keep, (v_q[NS-1] && !out_ready_i) |=> (v_q[NS-1] && $stable(q_q[NS-1])), "stalled result lost")
  // Reset empties the pipeline.
  `RTI_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> (v_q == '0), "valid bit set during reset")

endmodule

/* hdl/ray_triangle_intersect.sv */
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Segment/triangle intersection test, Moller-Trumbore, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Write the segment start, the segment vector and the determinant floor
//   through the cfg channel (index 0..6) while no beat is in flight; other
//   indexes are ignored. cfg_ready_o is always high.
//   Each s_axis beat carries one triangle (vertices a, b, c). Each m_axis
//   beat returns hit, hit_param (t scaled by 2^PARAM_FRAC_BITS, truncated)
//   and the miss cause, in input order.
// Throughput and stages:
//   One beat per cycle is accepted while the pipeline is not stalled (see
//   below). There are three stages for edges and cross products, five for
//   the dot products and bound tests, and one divider stage per bit of t.
// Reset and stalls:
//   Reset empties the pipeline and clears all configuration registers.
//   When m_axis_tready is low the pipeline holds its results and keeps
//   taking beats until every stage is full; then s_axis_tready drops.
// ----------------------------------------------------------------------------
module ray_triangle_intersect #(
  parameter int unsigned COORD_WIDTH     = 24,
  parameter int unsigned PARAM_FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rti_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [rti_pkg::CfgDataWidth-1:0]    cfg_data_i,
  // Triangle input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0 up: vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x,
  // vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, zero fill.
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
  // Result output stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // Fields from bit 0 up: hit, hit_param, miss_cause, zero fill.
  output logic [((PARAM_FRAC_BITS+5+7)/8)*8-1:0] m_axis_tdata
);
  import rti_pkg::*;

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned F   = PARAM_FRAC_BITS;
  localparam int unsigned EW  = CW + 1;
  localparam int unsigned PW  = 2 * CW + 3;
  localparam int unsigned DW  = 3 * CW + 6;
  localparam int unsigned OW  = ((F + 5 + 7) / 8) * 8;
  localparam int unsigned OUW = F + 2 + CauseWidth;

  logic signed [CW-1:0] start_q [3], dir_q [3];
  logic [DetFloorWidth-1:0] det_floor_q;

  logic signed [CW-1:0] va [3], vb [3], vc [3];

  logic                 g_valid, g_ready;
  logic signed [EW-1:0] e1 [3], e2 [3], sv [3], dv [3];
  logic signed [PW-1:0] pv [3], qv [3];

  logic                 t_valid, t_ready;
  cause_e               t_cause;
  logic signed [DW-1:0] t_det, t_tn;

  cause_e               o_cause;
  logic [F:0]           o_quot;
  logic                 o_hit;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= '{default: '0};
      dir_q       <= '{default: '0};
      det_floor_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_START_X:   start_q[0]  <= cfg_data_i[CW-1:0];
        REG_START_Y:   start_q[1]  <= cfg_data_i[CW-1:0];
        REG_START_Z:   start_q[2]  <= cfg_data_i[CW-1:0];
        REG_DIR_X:     dir_q[0]    <= cfg_data_i[CW-1:0];
        REG_DIR_Y:     dir_q[1]    <= cfg_data_i[CW-1:0];
        REG_DIR_Z:     dir_q[2]    <= cfg_data_i[CW-1:0];
        REG_DET_FLOOR: det_floor_q <= cfg_data_i[DetFloorWidth-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the vertices.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va[i] = s_axis_tdata[i*CW +: CW];
      vb[i] = s_axis_tdata[(3+i)*CW +: CW];
      vc[i] = s_axis_tdata[(6+i)*CW +: CW];
    end
  end

  rti_geom #(.CW(CW)) u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .va_i        (va),
    .vb_i        (vb),
    .vc_i        (vc),
    .start_i     (start_q),
    .dir_i       (dir_q),
    .out_valid_o (g_valid),
    .out_ready_i (g_ready),
    .e1_o        (e1),
    .e2_o        (e2),
    .s_o         (sv),
    .d_o         (dv),
    .p_o         (pv),
    .q_o         (qv)
  );

  rti_dot #(.CW(CW)) u_dot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (g_valid),
    .in_ready_o  (g_ready),
    .e1_i        (e1),
    .e2_i        (e2),
    .s_i         (sv),
    .d_i         (dv),
    .p_i         (pv),
    .q_i         (qv),
    .det_floor_i (det_floor_q),
    .out_valid_o (t_valid),
    .out_ready_i (t_ready),
    .cause_o     (t_cause),
    .det_o       (t_det),
    .tn_o        (t_tn)
  );

  rti_div #(.DW(DW), .F(F)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (t_valid),
    .in_ready_o  (t_ready),
    .cause_i     (t_cause),
    .det_i       (t_det),
    .tn_i        (t_tn),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cause_o     (o_cause),
    .quot_o      (o_quot)
  );

  // Pack the result; a miss reports zero for t.
  assign o_hit = (o_cause == CAUSE_HIT);
  assign m_axis_tdata = {{(OW-OUW){1'b0}}, o_cause,
                         (o_hit ? o_quot : {(F+1){1'b0}}), o_hit};

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the segment/triangle intersection block.
// ----------------------------------------------------------------------------
// Triangles are queued by the stimulus process and sent by a clocked driver
// with random gaps. Each accepted beat is run through an exact 128-bit
// integer intersection predictor. The predicted result is stored in order.
// A clocked monitor compares every result beat, field by field, with the
// oldest stored prediction. The segment registers and the determinant floor
// are changed between phases, and only once the block has drained.
// ----------------------------------------------------------------------------
module tb;
  import rti_pkg::*;

  localparam int unsigned CW = 24;
  localparam int unsigned FB = 16;
  localparam int unsigned WatchLimit = 4000;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [8:0][CW-1:0] tri_t;        // [0] = vertex_a_x, lowest bits
  typedef logic signed [127:0] wide_t;
  typedef struct packed {
    logic [2:0]  cause;
    logic [16:0] param;
    logic        hit;
  } isect_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i = '0;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [215:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  // Model copy of the configuration registers.
  coord_t ray_org [3];
  coord_t ray_vec [3];
  logic [31:0] det_floor_q;

  tri_t   tri_pending [$];
  isect_t isect_expected [$];
  int unsigned n_queued = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  logic in_beat = 1'b0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  int unsigned hold_cnt = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  logic no_idle = 1'b0;
  int unsigned quiet_cycles = 0;

  ray_triangle_intersect #(
    .COORD_WIDTH    (CW),
    .PARAM_FRAC_BITS(FB)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Clock, 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // Exact Moller-Trumbore test against the current segment.
  function automatic isect_t predict_isect(tri_t t);
    wide_t va [3];
    wide_t e1 [3];
    wide_t e2 [3];
    wide_t sv [3];
    wide_t dv [3];
    wide_t p [3];
    wide_t q [3];
    wide_t det, un, vn, tn, fl, quo;
    isect_t r;
    for (int i = 0; i < 3; i++) begin
      va[i] = $signed(t[i]);
      e1[i] = wide_t'($signed(t[3+i])) - va[i];
      e2[i] = wide_t'($signed(t[6+i])) - va[i];
      sv[i] = wide_t'(ray_org[i]) - va[i];
      dv[i] = ray_vec[i];
    end
    p[0] = dv[1] * e2[2] - dv[2] * e2[1];
    p[1] = dv[2] * e2[0] - dv[0] * e2[2];
    p[2] = dv[0] * e2[1] - dv[1] * e2[0];
    q[0] = sv[1] * e1[2] - sv[2] * e1[1];
    q[1] = sv[2] * e1[0] - sv[0] * e1[2];
    q[2] = sv[0] * e1[1] - sv[1] * e1[0];
    det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
    un  = sv[0] * p[0] + sv[1] * p[1] + sv[2] * p[2];
    vn  = dv[0] * q[0] + dv[1] * q[1] + dv[2] * q[2];
    tn  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
    // Fold the sign of det into the numerators so bounds need no division.
    if (det < 0) begin
      det = -det;
      un = -un;
      vn = -vn;
      tn = -tn;
    end
    fl = (det_floor_q == 0) ? wide_t'(1) : wide_t'({96'd0, det_floor_q});
    r = '0;
    if (det < fl) r.cause = CAUSE_PARALLEL;
    else if (un < 0 || un > det) r.cause = CAUSE_U_OUT;
    else if (vn < 0 || un + vn > det) r.cause = CAUSE_V_OUT;
    else if (tn < 0 || tn > det) r.cause = CAUSE_T_OUT;
    else begin
      quo = (tn <<< FB) / det;
      r.cause = CAUSE_HIT;
      r.param = quo[16:0];
      r.hit = 1'b1;
    end
    return r;
  endfunction

  // Triangle driver: holds a beat until accepted, then moves on.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_beat) begin
        isect_expected.push_back(predict_isect(tri_pending.pop_front()));
      end
      if (!s_axis_tvalid || in_beat) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (tri_pending.size() != 0) begin
          s_axis_tdata <= tri_pending[0];
          s_axis_tvalid <= 1'b1;
          tx_gap <= pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver, with one long hold-off on request.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_cnt <= 400;
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        rx_gap <= pick_gap();
      end
    end
  end

  // Monitor: flag input beats and check result beats.
  always @(posedge clk_i) begin
    isect_t got, want;
    in_beat = rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = isect_t'(m_axis_tdata[20:0]);
      if (isect_expected.size() == 0) begin
        $display("%0t: result beat with none expected: %h", $realtime, m_axis_tdata);
        n_errors++;
      end else begin
        want = isect_expected.pop_front();
        if (got.hit !== want.hit) begin
          $display("%0t: hit expected %0d got %0d", $realtime, want.hit, got.hit);
          n_errors++;
        end
        if (got.param !== want.param) begin
          $display("%0t: hit_param expected %0d got %0d", $realtime, want.param, got.param);
          n_errors++;
        end
        if (got.cause !== want.cause) begin
          $display("%0t: miss_cause expected %0d got %0d", $realtime, want.cause, got.cause);
          n_errors++;
        end
      end
      if (m_axis_tdata[23:21] !== 3'b000) begin
        $display("%0t: fill bits expected 0 got %b", $realtime, m_axis_tdata[23:21]);
        n_errors++;
      end
      n_checked++;
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
          || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchLimit) begin
        $display("tb: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic coord_t clamp_coord(longint v);
    if (v > 8388607) return coord_t'(8388607);
    if (v < -8388608) return coord_t'(-8388608);
    return coord_t'(v);
  endfunction

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_START_X:   ray_org[0] = val[CW-1:0];
      REG_START_Y:   ray_org[1] = val[CW-1:0];
      REG_START_Z:   ray_org[2] = val[CW-1:0];
      REG_DIR_X:     ray_vec[0] = val[CW-1:0];
      REG_DIR_Y:     ray_vec[1] = val[CW-1:0];
      REG_DIR_Z:     ray_vec[2] = val[CW-1:0];
      REG_DET_FLOOR: det_floor_q = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_segment(longint sx, longint sy, longint sz,
                             longint dx, longint dy, longint dz, logic [31:0] fl);
    write_reg(REG_START_X, {8'($urandom_range(0, 255)), 24'(sx)});
    write_reg(REG_START_Y, {8'($urandom_range(0, 255)), 24'(sy)});
    write_reg(REG_START_Z, {8'($urandom_range(0, 255)), 24'(sz)});
    write_reg(REG_DIR_X, {8'($urandom_range(0, 255)), 24'(dx)});
    write_reg(REG_DIR_Y, {8'($urandom_range(0, 255)), 24'(dy)});
    write_reg(REG_DIR_Z, {8'($urandom_range(0, 255)), 24'(dz)});
    write_reg(REG_DET_FLOOR, fl);
  endtask

  task automatic send_tri(longint ax, longint ay, longint az, longint bx, longint by,
                          longint bz, longint cx, longint cy, longint cz);
    tri_t t;
    t[0] = clamp_coord(ax); t[1] = clamp_coord(ay); t[2] = clamp_coord(az);
    t[3] = clamp_coord(bx); t[4] = clamp_coord(by); t[5] = clamp_coord(bz);
    t[6] = clamp_coord(cx); t[7] = clamp_coord(cy); t[8] = clamp_coord(cz);
    tri_pending.push_back(t);
    n_queued++;
  endtask

  // Triangle scattered around a point on (or near) the segment line.
  task automatic send_near_tri();
    longint px, py, pz, tau, r;
    longint o [9];
    tau = longint'($urandom_range(0, 320)) - 32;
    px = ray_org[0] + (longint'(ray_vec[0]) * tau) / 256;
    py = ray_org[1] + (longint'(ray_vec[1]) * tau) / 256;
    pz = ray_org[2] + (longint'(ray_vec[2]) * tau) / 256;
    r = longint'(1) << $urandom_range(2, 22);
    for (int i = 0; i < 9; i++) o[i] = longint'($urandom_range(0, 2 * r)) - r;
    send_tri(px + o[0], py + o[1], pz + o[2], px + o[3], py + o[4], pz + o[5],
             px + o[6], py + o[7], pz + o[8]);
  endtask

  task automatic send_any_tri();
    tri_t t;
    for (int i = 0; i < 9; i++) t[i] = CW'($urandom());
    tri_pending.push_back(t);
    n_queued++;
  endtask

  task automatic drain();
    while (n_checked != n_queued) @(negedge clk_i);
  endtask

  task automatic random_phase(int unsigned n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7) send_near_tri();
      else send_any_tri();
    end
    drain();
  endtask

  initial begin
    rst_ni <= 1'b0;
    ray_org = '{default: '0};
    ray_vec = '{default: '0};
    det_floor_q = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: zero direction, so everything is parallel.
    send_tri(0, 0, 0, 1000, 0, 0, 0, 1000, 0);
    drain();

    // Directed cases against a segment along +z through the xy plane.
    set_segment(100, 100, -1000, 0, 0, 2000, 0);
    write_reg(3'd7, 32'hFFFF_FFFF);   // unmapped index, must be ignored
    send_tri(0, 0, 0, 1000, 0, 0, 0, 1000, 0);          // plain hit, t = 1/2
    send_tri(0, 0, 0, 0, 1000, 0, 1000, 0, 0);          // hit, reversed winding
    send_tri(200, 0, 0, 1200, 0, 0, 200, 1000, 0);      // u outside
    send_tri(0, 200, 0, 1000, 200, 0, 0, 1200, 0);      // v outside
    send_tri(0, 0, 0, 150, 0, 0, 0, 150, 0);            // u + v beyond 1
    send_tri(100, 100, 0, 1100, 100, 0, 100, 1100, 0);  // u and v exactly 0
    send_tri(0, 0, 0, 200, 0, 0, 0, 200, 0);            // u + v exactly 1
    send_tri(0, 0, -1000, 1000, 0, -1000, 0, 1000, -1000);  // t exactly 0
    send_tri(0, 0, 1000, 1000, 0, 1000, 0, 1000, 1000);     // t exactly 1
    send_tri(0, 0, 5000, 1000, 0, 5000, 0, 1000, 5000);     // t beyond 1
    send_tri(0, 0, -5000, 1000, 0, -5000, 0, 1000, -5000);  // t below 0
    send_tri(0, 0, 0, 0, 0, 0, 0, 1000, 0);             // degenerate
    send_tri(0, 0, 0, 1000, 0, 0, 1000, 0, 1000);       // parallel plane
    send_tri(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
             8388607, 8388607, 8388607);
    send_tri(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
             -8388608, -8388608, -8388608);
    send_tri(-8388608, -8388608, 0, 8388607, -8388608, 0, -8388608, 8388607, 0);
    send_tri(8388607, -8388608, 8388607, -8388608, 8388607, -8388608,
             8388607, 8388607, -8388608);
    drain();
    write_reg(REG_DET_FLOOR, 32'hFFFF_FFFF);  // everything small now is parallel
    send_tri(0, 0, 0, 1000, 0, 0, 0, 1000, 0);
    send_tri(-8388608, -8388608, 0, 8388607, -8388608, 0, -8388608, 8388607, 0);
    drain();

    // Random phases over a range of segments and floors.
    set_segment(-3000, 2000, 500, 6000, -4000, 9000, 0);
    no_idle = 1'b1;
    random_phase(240);
    no_idle = 1'b0;
    set_segment($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
                $urandom_range(0, 2000) - 1000, $urandom_range(0, 100000) - 50000,
                $urandom_range(0, 100000) - 50000, $urandom_range(0, 100000) - 50000,
                $urandom_range(1, 1000));
    // The receiver holds off while triangles keep coming, to fill the pipe.
    hold_req = 1'b1;
    random_phase(250);
    set_segment(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 1);
    random_phase(240);
    set_segment(8388607, 8388607, 8388607, -8388608, -8388608, -8388608, 0);
    random_phase(240);
    set_segment($urandom_range(0, 4000000) - 2000000, $urandom_range(0, 4000000) - 2000000,
                $urandom_range(0, 4000000) - 2000000, $urandom_range(0, 4000000) - 2000000,
                $urandom_range(0, 4000000) - 2000000, $urandom_range(0, 4000000) - 2000000,
                $urandom());
    random_phase(240);
    set_segment(0, 0, 0, 8388607, 0, -8388608, 32'hFFFF_FFFF);
    random_phase(240);
    set_segment(12345, -54321, 777, -200000, 300000, 100000, 32'h0001_0000);
    random_phase(240);
    set_segment($urandom_range(0, 20000) - 10000, $urandom_range(0, 20000) - 10000,
                $urandom_range(0, 20000) - 10000, $urandom_range(0, 2000000) - 1000000,
                $urandom_range(0, 2000000) - 1000000, $urandom_range(0, 2000000) - 1000000,
                0);
    no_idle = 1'b1;
    random_phase(120);
    no_idle = 1'b0;
    random_phase(120);

    repeat (40) @(negedge clk_i);
    if (n_errors == 0 && isect_expected.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/rti_pkg.sv
hdl/rti_geom.sv
hdl/rti_dot.sv
hdl/rti_div.sv
hdl/ray_triangle_intersect.sv
tb/sv/tb.sv
